FILE: rtl/dynamic_line_hull_max_query_top_macros.svh
// Assertion macros shared by the line hull RTL.
// No dependencies; included by the top module, which carries the assertions.
`ifndef DYNAMIC_LINE_HULL_MAX_QUERY_TOP_MACROS_SVH
`define DYNAMIC_LINE_HULL_MAX_QUERY_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define DLH_ASSERT_IMPL(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define DLH_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: rtl/dlh_pkg.sv
// Types and constants of the line hull block.
// No dependencies; used by every module of the block.
package dlh_pkg;

  localparam int MAX_LINES = 1024;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int BP_W      = 35;

  localparam logic signed [BP_W-1:0] BP_INF = {1'b0, {(BP_W-1){1'b1}}};
  localparam logic signed [BP_W-1:0] BP_NEG = {1'b1, {(BP_W-1){1'b0}}};

  localparam logic       ACT_INSERT = 1'b0;
  localparam logic       ACT_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               action;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] query_point;
  } req_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic signed [31:0]     slope;
    logic signed [31:0]     intercept;
    logic signed [BP_W-1:0] bp;
  } line_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT,
    CELL_BP
  } cell_op_e;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH,
    CH_POP,
    CH_DROP2,
    CH_SETBP
  } chain_op_e;

  typedef struct packed {
    chain_op_e              op;
    line_t                  line;
    logic signed [BP_W-1:0] bp;
  } chain_cmd_t;

endpackage

FILE: rtl/dlh_cell.sv
// One storage cell of a line stack: holds a line and its breakpoint.
// Depends on dlh_pkg.
module dlh_cell (
  input  logic                        clk_i,
  input  dlh_pkg::cell_op_e           op_i,
  input  dlh_pkg::line_t              prev_i,
  input  dlh_pkg::line_t              next_i,
  input  logic signed [dlh_pkg::BP_W-1:0] bp_i,
  output dlh_pkg::line_t              line_o
);

  dlh_pkg::line_t line_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      dlh_pkg::CELL_HOLD: line_q <= line_q;
      dlh_pkg::CELL_PREV: line_q <= prev_i;
      dlh_pkg::CELL_NEXT: line_q <= next_i;
      dlh_pkg::CELL_BP:   line_q.bp <= bp_i;
      default:            line_q <= line_q;
    endcase
  end

  assign line_o = line_q;

endmodule

FILE: rtl/dlh_chain.sv
// Stack of lines built as a row of cells; the top sits in cell zero.
// Depends on dlh_pkg and dlh_cell.
module dlh_chain (
  input  logic                 clk_i,
  input  dlh_pkg::chain_cmd_t  cmd_i,
  output dlh_pkg::line_t       head_o,
  output dlh_pkg::line_t       second_o
);

  dlh_pkg::line_t lines [dlh_pkg::MAX_LINES];

  for (genvar i = 0; i < dlh_pkg::MAX_LINES; i++) begin : g_cell
    dlh_pkg::cell_op_e op;
    dlh_pkg::line_t    prv;
    dlh_pkg::line_t    nxt;

    if (i == 0) begin : g_first
      assign prv = cmd_i.line;
    end else begin : g_mid
      assign prv = lines[i-1];
    end

    if (i == dlh_pkg::MAX_LINES - 1) begin : g_last
      assign nxt = lines[i];
    end else begin : g_inner
      assign nxt = lines[i+1];
    end

    // Dropping the second entry keeps the top, so cell zero only loads its breakpoint.
    always_comb begin
      unique case (cmd_i.op)
        dlh_pkg::CH_PUSH:  op = dlh_pkg::CELL_PREV;
        dlh_pkg::CH_POP:   op = dlh_pkg::CELL_NEXT;
        dlh_pkg::CH_DROP2: op = (i == 0) ? dlh_pkg::CELL_BP : dlh_pkg::CELL_NEXT;
        dlh_pkg::CH_SETBP: op = (i == 0) ? dlh_pkg::CELL_BP : dlh_pkg::CELL_HOLD;
        default:           op = dlh_pkg::CELL_HOLD;
      endcase
    end

    dlh_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .prev_i (prv),
      .next_i (nxt),
      .bp_i   (cmd_i.bp),
      .line_o (lines[i])
    );
  end

  assign head_o   = lines[0];
  assign second_o = lines[1];

endmodule

FILE: rtl/dlh_cross.sv
// Breakpoint unit: floored intersection of two lines, one quotient bit a cycle.
// Depends on dlh_pkg.
module dlh_cross (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  dlh_pkg::line_t              a_i,
  input  dlh_pkg::line_t              b_i,
  output logic                        done_o,
  output logic signed [dlh_pkg::BP_W-1:0] bp_o
);

  typedef enum logic [1:0] {
    X_IDLE,
    X_RUN,
    X_FIN,
    X_DONE
  } xstate_e;

  xstate_e     state_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q;
  logic [32:0] quo_q;
  logic [32:0] dmag_q;
  logic        neg_q;
  logic signed [dlh_pkg::BP_W-1:0] bp_q;

  logic signed [32:0] num;
  logic signed [32:0] den;
  logic [33:0]        trial;
  logic               fit;
  logic [dlh_pkg::BP_W-1:0] qext;

  assign num   = 33'(b_i.intercept) - 33'(a_i.intercept);
  assign den   = 33'(a_i.slope) - 33'(b_i.slope);
  assign trial = {rem_q, quo_q[32]};
  assign fit   = trial >= {1'b0, dmag_q};
  assign qext  = {2'b00, quo_q} + {{(dlh_pkg::BP_W-1){1'b0}}, (rem_q != '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= X_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        X_IDLE: begin
          cnt_q <= '0;
          if (start_i) begin
            state_q <= (a_i.slope == b_i.slope) ? X_DONE : X_RUN;
          end
        end
        X_RUN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) begin
            state_q <= X_FIN;
          end
        end
        X_FIN:   state_q <= X_DONE;
        X_DONE:  state_q <= X_IDLE;
        default: state_q <= X_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      X_IDLE: begin
        if (start_i) begin
          bp_q   <= (a_i.intercept > b_i.intercept) ? dlh_pkg::BP_INF : dlh_pkg::BP_NEG;
          rem_q  <= '0;
          quo_q  <= num[32] ? 33'(-num) : 33'(num);
          dmag_q <= den[32] ? 33'(-den) : 33'(den);
          neg_q  <= num[32] ^ den[32];
        end
      end
      X_RUN: begin
        rem_q <= fit ? 33'(trial - {1'b0, dmag_q}) : trial[32:0];
        quo_q <= {quo_q[31:0], fit};
      end
      X_FIN: begin
        // Rounding toward minus infinity adds one to the magnitude of an inexact negative.
        bp_q <= neg_q ? $signed(-qext) : $signed({2'b00, quo_q});
      end
      default: begin
        bp_q <= bp_q;
      end
    endcase
  end

  assign done_o = (state_q == X_DONE);
  assign bp_o   = bp_q;

endmodule

FILE: rtl/dynamic_line_hull_max_query_top.sv
// Upper envelope of lines with insert and maximum query, top level.
// Depends on dlh_pkg, dlh_chain, dlh_cross and the assertion macro header.
//
//   channel | direction | handshake                  | payload
//   in      | request   | in_valid_i / in_stall_o    | in_req_i  (dlh_pkg::req_t)
//   out     | result    | out_valid_o / out_stall_i  | out_res_o (dlh_pkg::res_t)
//
// The lines sit in two stacks of cells on either side of a cursor; each move
// of the cursor shifts both stacks by one cell. A query walks the cursor to
// its point, multiplies in S_MUL, adds the intercept in S_QEND and passes
// the result on in S_OUT. An insert walks to its slope; the breakpoint unit
// computes breakpoints one quotient bit a cycle; equal slopes skip division.
// Reset empties the envelope at once; no clearing pass is needed.
// One request is in work at a time; a finished result waits in the output
// register while the next request is already taken.
`include "dynamic_line_hull_max_query_top_macros.svh"

module dynamic_line_hull_max_query_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dlh_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dlh_pkg::res_t out_res_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FINDI,
    S_FINDQ,
    S_MUL,
    S_QEND,
    S_A,
    S_B,
    S_B2,
    S_C,
    S_C2,
    S_C3,
    S_XW,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    P_A,
    P_B,
    P_B2,
    P_C
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [dlh_pkg::CNT_W-1:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [dlh_pkg::CNT_W:0]   total;
  logic                      out_valid_q, out_valid_d;

  dlh_pkg::req_t      req_q, req_d;
  dlh_pkg::res_t      res_q, res_d, out_q, out_d;
  logic signed [63:0] prod_q, prod_d;

  dlh_pkg::chain_cmd_t l_cmd, r_cmd;
  dlh_pkg::line_t      l_head, l_sec, r_head, r_sec;
  dlh_pkg::line_t      x_a, x_b, new_line;
  logic                x_start, x_done;
  logic signed [dlh_pkg::BP_W-1:0] x_bp, px;

  dlh_chain u_left (
    .clk_i    (clk_i),
    .cmd_i    (l_cmd),
    .head_o   (l_head),
    .second_o (l_sec)
  );

  dlh_chain u_right (
    .clk_i    (clk_i),
    .cmd_i    (r_cmd),
    .head_o   (r_head),
    .second_o (r_sec)
  );

  assign x_a = (state_q == S_A) ? r_head : l_head;
  assign x_b = (state_q == S_A) ? r_sec  : r_head;

  dlh_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (x_start),
    .a_i     (x_a),
    .b_i     (x_b),
    .done_o  (x_done),
    .bp_o    (x_bp)
  );

  assign total = {1'b0, lcnt_q} + {1'b0, rcnt_q};
  assign px    = dlh_pkg::BP_W'(req_q.query_point);

  always_comb begin
    new_line.slope     = req_q.slope;
    new_line.intercept = req_q.intercept;
    new_line.bp        = '0;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    req_d       = req_q;
    res_d       = res_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    x_start     = 1'b0;
    l_cmd.op    = dlh_pkg::CH_HOLD;
    l_cmd.line  = r_head;
    l_cmd.bp    = x_bp;
    r_cmd.op    = dlh_pkg::CH_HOLD;
    r_cmd.line  = l_head;
    r_cmd.bp    = x_bp;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          res_d.value  = '0;
          res_d.status = dlh_pkg::ST_OK;
          if (in_req_i.action == dlh_pkg::ACT_INSERT) begin
            if (total >= (dlh_pkg::CNT_W + 1)'(dlh_pkg::MAX_LINES)) begin
              res_d.status = dlh_pkg::ST_FULL;
              state_d      = S_OUT;
            end else begin
              state_d = S_FINDI;
            end
          end else if (total == '0) begin
            res_d.status = dlh_pkg::ST_EMPTY;
            state_d      = S_OUT;
          end else begin
            state_d = S_FINDQ;
          end
        end
      end
      S_FINDI: begin
        priority if (lcnt_q != '0 && l_head.slope > req_q.slope) begin
          l_cmd.op = dlh_pkg::CH_POP;
          r_cmd.op = dlh_pkg::CH_PUSH;
          lcnt_d   = lcnt_q - 1'b1;
          rcnt_d   = rcnt_q + 1'b1;
        end else if (rcnt_q != '0 && r_head.slope <= req_q.slope) begin
          r_cmd.op = dlh_pkg::CH_POP;
          l_cmd.op = dlh_pkg::CH_PUSH;
          rcnt_d   = rcnt_q - 1'b1;
          lcnt_d   = lcnt_q + 1'b1;
        end else begin
          r_cmd.op   = dlh_pkg::CH_PUSH;
          r_cmd.line = new_line;
          rcnt_d     = rcnt_q + 1'b1;
          state_d    = S_A;
        end
      end
      S_FINDQ: begin
        priority if (lcnt_q != '0 && l_head.bp >= px) begin
          l_cmd.op = dlh_pkg::CH_POP;
          r_cmd.op = dlh_pkg::CH_PUSH;
          lcnt_d   = lcnt_q - 1'b1;
          rcnt_d   = rcnt_q + 1'b1;
        end else if (rcnt_q != '0 && r_head.bp < px) begin
          r_cmd.op = dlh_pkg::CH_POP;
          l_cmd.op = dlh_pkg::CH_PUSH;
          rcnt_d   = rcnt_q - 1'b1;
          lcnt_d   = lcnt_q + 1'b1;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = r_head.slope * req_q.query_point;
        state_d = S_QEND;
      end
      S_QEND: begin
        res_d.value  = prod_q + 64'(r_head.intercept);
        res_d.status = dlh_pkg::ST_OK;
        state_d      = S_OUT;
      end
      // Drop the lines to the right that the new line covers.
      S_A: begin
        if (rcnt_q == (dlh_pkg::CNT_W)'(1)) begin
          r_cmd.op = dlh_pkg::CH_SETBP;
          r_cmd.bp = dlh_pkg::BP_INF;
          state_d  = S_B;
        end else begin
          x_start = 1'b1;
          phase_d = P_A;
          state_d = S_XW;
        end
      end
      S_B: begin
        if (lcnt_q == '0) begin
          state_d = S_C;
        end else begin
          x_start = 1'b1;
          phase_d = P_B;
          state_d = S_XW;
        end
      end
      S_B2: begin
        if (rcnt_q == '0) begin
          l_cmd.op = dlh_pkg::CH_SETBP;
          l_cmd.bp = dlh_pkg::BP_INF;
          state_d  = S_C;
        end else begin
          x_start = 1'b1;
          phase_d = P_B2;
          state_d = S_XW;
        end
      end
      // Walk left and drop the lines on the left that became useless.
      S_C: begin
        if (lcnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          l_cmd.op = dlh_pkg::CH_POP;
          r_cmd.op = dlh_pkg::CH_PUSH;
          lcnt_d   = lcnt_q - 1'b1;
          rcnt_d   = rcnt_q + 1'b1;
          state_d  = S_C2;
        end
      end
      S_C2: begin
        if (lcnt_q == '0 || l_head.bp < r_head.bp) begin
          state_d = S_OUT;
        end else begin
          r_cmd.op = dlh_pkg::CH_POP;
          rcnt_d   = rcnt_q - 1'b1;
          state_d  = S_C3;
        end
      end
      S_C3: begin
        if (rcnt_q == '0) begin
          l_cmd.op = dlh_pkg::CH_SETBP;
          l_cmd.bp = dlh_pkg::BP_INF;
          state_d  = S_C;
        end else begin
          x_start = 1'b1;
          phase_d = P_C;
          state_d = S_XW;
        end
      end
      S_XW: begin
        if (x_done) begin
          unique case (phase_q)
            P_A: begin
              if (x_bp >= r_sec.bp) begin
                r_cmd.op = dlh_pkg::CH_DROP2;
                rcnt_d   = rcnt_q - 1'b1;
                state_d  = S_A;
              end else begin
                r_cmd.op = dlh_pkg::CH_SETBP;
                state_d  = S_B;
              end
            end
            P_B: begin
              l_cmd.op = dlh_pkg::CH_SETBP;
              if (x_bp >= r_head.bp) begin
                r_cmd.op = dlh_pkg::CH_POP;
                rcnt_d   = rcnt_q - 1'b1;
                state_d  = S_B2;
              end else begin
                state_d = S_C;
              end
            end
            P_B2, P_C: begin
              l_cmd.op = dlh_pkg::CH_SETBP;
              state_d  = S_C;
            end
            default: state_d = S_C;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_A;
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      lcnt_q      <= lcnt_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `DLH_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, total <= (dlh_pkg::CNT_W + 1)'(dlh_pkg::MAX_LINES), "line count exceeds capacity")
  `DLH_ASSERT_IMPL(a_query_nonempty, clk_i, rst_ni, state_q == S_FINDQ, total != '0, "query walk on empty envelope")
  `DLH_ASSERT_IMPL(a_cross_operand, clk_i, rst_ni, x_start, rcnt_q != '0, "breakpoint started without a right line")
  `DLH_ASSERT_NEXT(a_cross_busy, clk_i, rst_ni, x_start && (x_a.slope != x_b.slope), !x_done, "breakpoint unit done too early")
  `DLH_ASSERT_IMPL(a_left_sorted, clk_i, rst_ni, lcnt_q >= (dlh_pkg::CNT_W)'(2), l_sec.slope <= l_head.slope, "left stack out of order")

endmodule
